### rtl/bcpa_pkg.sv
// Shared constants, operation and status codes, and transfer types of the page allocator.
`default_nettype none

package bcpa_pkg;

	// Pool geometry
	localparam int MAX_PAGES = 1024;
	localparam int PAGE_W    = 10;                  // page number width
	localparam int CNT_W     = 11;                  // page count width
	localparam int WORD_W    = 32;                  // bitmap word width
	localparam int BIT_AW    = 5;                   // bit index within a word
	localparam int WORD_CNT  = MAX_PAGES / WORD_W;  // bitmap words
	localparam int WORD_AW   = PAGE_W - BIT_AW;     // word address width
	localparam int CHUNK_W   = 8;                   // pages examined per scan cycle
	localparam int CHUNK_AW  = 3;                   // bit index within a chunk

	localparam logic [CNT_W-1:0] MAX_PAGES_C = CNT_W'(MAX_PAGES);
	localparam logic [CNT_W-1:0] TOTAL_RST   = CNT_W'(1024);

	// Operation codes
	localparam logic [1:0] FUNC_ALLOC    = 2'd0;
	localparam logic [1:0] FUNC_FREE_ONE = 2'd1;
	localparam logic [1:0] FUNC_FREE_ALL = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_FREE = 2'd1;
	localparam logic [1:0] STAT_NO_FIT  = 2'd2;
	localparam logic [1:0] STAT_BAD     = 2'd3;

	typedef struct packed {
		logic [1:0]        func;
		logic [CNT_W-1:0]  page_count;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] start_page;
		logic [CNT_W-1:0]  free_pages;
	} resp_t;

endpackage

`default_nettype wire

### rtl/bitmap_contiguous_page_allocator.sv
// First-fit contiguous page allocator over a word-organized free-page bitmap.
`default_nettype none

// One bit per page (1 = used) lives in a 32-word by 32-bit memory with one read
// and one write port; a row-valid flop per word lets free-all clear every row at
// once, and rows never written read as all free. The block takes one request at
// a time and drops in_ready while it works. An allocate scans from page 0 with a
// shared run counter that examines 8 pages per cycle while checking: each bitmap
// word is first read in ST_SCAN_RD, which holds the scan, then checked as four
// chunks in ST_SCAN_CHK; the found run is then marked with a read-modify-write
// (ST_MARK_RD, ST_MARK_WR) of each word it covers. Free-one reads the word of
// the page and writes it back with that bit cleared if it was set. The result
// sits in an output register, so the next request is taken while a result still
// waits. total_pages may be written only while idle, and software issues
// free-all after changing it.
module bitmap_contiguous_page_allocator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire bcpa_pkg::req_t          in_data,
	output logic                         out_valid,
	input  wire                          out_ready,
	output bcpa_pkg::resp_t              out_data,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [bcpa_pkg::CNT_W-1:0]    cfg_data
);

	// Sequencer states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SCAN_RD  = 4'd1;
	localparam logic [3:0] ST_SCAN_CHK = 4'd2;
	localparam logic [3:0] ST_MARK_SET = 4'd3;
	localparam logic [3:0] ST_MARK_RD  = 4'd4;
	localparam logic [3:0] ST_MARK_WR  = 4'd5;
	localparam logic [3:0] ST_FREE_RD  = 4'd6;
	localparam logic [3:0] ST_FREE_WR  = 4'd7;
	localparam logic [3:0] ST_FIN      = 4'd8;

	logic [3:0]                       state_q;
	logic [bcpa_pkg::CNT_W-1:0]       total_q;
	logic [bcpa_pkg::CNT_W-1:0]       fc_q;
	logic [bcpa_pkg::CNT_W-1:0]       want_q;
	logic [bcpa_pkg::PAGE_W-1:0]      pg_q;
	logic [bcpa_pkg::CNT_W-1:0]       pos_q;
	logic [bcpa_pkg::CNT_W-1:0]       run_q;
	logic [bcpa_pkg::PAGE_W-1:0]      end_q;
	logic [bcpa_pkg::PAGE_W-1:0]      start_q;
	logic [bcpa_pkg::WORD_AW-1:0]     wa_q;
	logic [1:0]                       res_status_q;
	logic [bcpa_pkg::PAGE_W-1:0]      res_start_q;
	logic                             out_valid_q;
	bcpa_pkg::resp_t                  out_data_q;
	logic [bcpa_pkg::WORD_CNT-1:0]    row_vld_q;

	// Bitmap memory and its ports
	logic [bcpa_pkg::WORD_W-1:0]      map_mem [bcpa_pkg::WORD_CNT];
	logic [bcpa_pkg::WORD_W-1:0]      rd_data_q;
	logic                             rd_vld_q;
	logic                             rd_en;
	logic [bcpa_pkg::WORD_AW-1:0]     rd_addr;
	logic                             wr_en;
	logic [bcpa_pkg::WORD_AW-1:0]     wr_addr;
	logic [bcpa_pkg::WORD_W-1:0]      wr_data;
	logic [bcpa_pkg::WORD_W-1:0]      rd_word;

	logic [bcpa_pkg::CNT_W-1:0]       pool;
	logic                             in_xfer;
	logic                             out_load;
	logic [bcpa_pkg::CHUNK_W-1:0]     chunk;
	logic [bcpa_pkg::CNT_W-1:0]       run_nxt;
	logic                             hit;
	logic [bcpa_pkg::PAGE_W-1:0]      hit_end;
	logic [bcpa_pkg::CNT_W-1:0]       pos_nxt;
	logic [bcpa_pkg::CNT_W-1:0]       start_calc;
	logic [bcpa_pkg::WORD_W-1:0]      mark_mask;
	logic [bcpa_pkg::WORD_W-1:0]      clr_mask;

	assign pool      = (total_q > bcpa_pkg::MAX_PAGES_C) ? bcpa_pkg::MAX_PAGES_C : total_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign rd_word   = rd_vld_q ? rd_data_q : '0;
	assign chunk     = rd_word[{pos_q[bcpa_pkg::BIT_AW-1:bcpa_pkg::CHUNK_AW],
		{bcpa_pkg::CHUNK_AW{1'b0}}} +: bcpa_pkg::CHUNK_W];
	assign pos_nxt   = pos_q + bcpa_pkg::CNT_W'(bcpa_pkg::CHUNK_W);
	assign start_calc = {1'b0, end_q} - want_q + bcpa_pkg::CNT_W'(1);
	assign clr_mask  = bcpa_pkg::WORD_W'(1) << pg_q[bcpa_pkg::BIT_AW-1:0];

	// Advance the free-run counter over one chunk of eight pages
	always_comb begin
		logic [bcpa_pkg::CNT_W-1:0] idx;
		run_nxt = run_q;
		hit     = 1'b0;
		hit_end = '0;
		for (int b = 0; b < bcpa_pkg::CHUNK_W; b++) begin
			idx = pos_q + bcpa_pkg::CNT_W'(b);
			if (!hit && (idx < pool)) begin
				run_nxt = chunk[b] ? '0 : run_nxt + bcpa_pkg::CNT_W'(1);
				if (run_nxt == want_q) begin
					hit     = 1'b1;
					hit_end = idx[bcpa_pkg::PAGE_W-1:0];
				end
			end
		end
	end

	// Select the bits of the current word that fall inside the found run
	always_comb begin
		logic [bcpa_pkg::PAGE_W-1:0] page;
		for (int b = 0; b < bcpa_pkg::WORD_W; b++) begin
			page         = {wa_q, bcpa_pkg::BIT_AW'(b)};
			mark_mask[b] = (page >= start_q) && (page <= end_q);
		end
	end

	// Drive the memory ports from the sequencer state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_AW];
		wr_en   = 1'b0;
		wr_addr = wa_q;
		wr_data = rd_word | mark_mask;
		unique case (state_q)
			ST_SCAN_RD: begin
				rd_en = 1'b1;
			end
			ST_MARK_RD: begin
				rd_en   = 1'b1;
				rd_addr = wa_q;
			end
			ST_MARK_WR: begin
				wr_en = 1'b1;
			end
			ST_FREE_RD: begin
				rd_en   = 1'b1;
				rd_addr = pg_q[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_AW];
			end
			ST_FREE_WR: begin
				wr_en   = |(rd_word & clr_mask);
				wr_addr = pg_q[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_AW];
				wr_data = rd_word & ~clr_mask;
			end
			default: begin
			end
		endcase
	end

	// Bitmap storage: registered read, single write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= map_mem[rd_addr];
			rd_vld_q  <= row_vld_q[rd_addr];
		end
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
	end

	// Sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			total_q      <= bcpa_pkg::TOTAL_RST;
			fc_q         <= bcpa_pkg::MAX_PAGES_C;
			row_vld_q    <= '0;
			want_q       <= '0;
			pg_q         <= '0;
			pos_q        <= '0;
			run_q        <= '0;
			end_q        <= '0;
			start_q      <= '0;
			wa_q         <= '0;
			res_status_q <= bcpa_pkg::STAT_OK;
			res_start_q  <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			// Register write
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end

			// Mark each written row as holding real data
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end

			// Hold the result until the downstream transfer
			if (out_load) begin
				out_valid_q           <= 1'b1;
				out_data_q.status     <= res_status_q;
				out_data_q.start_page <= res_start_q;
				out_data_q.free_pages <= fc_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						want_q       <= in_data.page_count;
						pg_q         <= in_data.page_number;
						pos_q        <= '0;
						run_q        <= '0;
						res_start_q  <= '0;
						res_status_q <= bcpa_pkg::STAT_OK;
						unique case (in_data.func)
							bcpa_pkg::FUNC_ALLOC: begin
								if (fc_q == '0) begin
									res_status_q <= bcpa_pkg::STAT_NO_FREE;
									state_q      <= ST_FIN;
								end else if (in_data.page_count == '0) begin
									res_status_q <= bcpa_pkg::STAT_BAD;
									state_q      <= ST_FIN;
								end else begin
									state_q <= ST_SCAN_RD;
								end
							end
							bcpa_pkg::FUNC_FREE_ONE: begin
								if ({1'b0, in_data.page_number} >= pool) begin
									res_status_q <= bcpa_pkg::STAT_BAD;
									state_q      <= ST_FIN;
								end else begin
									state_q <= ST_FREE_RD;
								end
							end
							bcpa_pkg::FUNC_FREE_ALL: begin
								row_vld_q <= '0;
								fc_q      <= pool;
								state_q   <= ST_FIN;
							end
							default: begin
								res_status_q <= bcpa_pkg::STAT_BAD;
								state_q      <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (hit) begin
						end_q   <= hit_end;
						state_q <= ST_MARK_SET;
					end else if (pos_nxt >= pool) begin
						res_status_q <= bcpa_pkg::STAT_NO_FIT;
						state_q      <= ST_FIN;
					end else begin
						pos_q <= pos_nxt;
						run_q <= run_nxt;
						// Fetch the next word after its last chunk
						if (&pos_q[bcpa_pkg::BIT_AW-1:bcpa_pkg::CHUNK_AW]) begin
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_MARK_SET: begin
					start_q     <= start_calc[bcpa_pkg::PAGE_W-1:0];
					res_start_q <= start_calc[bcpa_pkg::PAGE_W-1:0];
					wa_q        <= start_calc[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_AW];
					state_q     <= ST_MARK_RD;
				end
				ST_MARK_RD: begin
					state_q <= ST_MARK_WR;
				end
				ST_MARK_WR: begin
					if (wa_q == end_q[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_AW]) begin
						fc_q    <= (fc_q > want_q) ? fc_q - want_q : '0;
						state_q <= ST_FIN;
					end else begin
						wa_q    <= wa_q + bcpa_pkg::WORD_AW'(1);
						state_q <= ST_MARK_RD;
					end
				end
				ST_FREE_RD: begin
					state_q <= ST_FREE_WR;
				end
				ST_FREE_WR: begin
					if (|(rd_word & clr_mask) && (fc_q < bcpa_pkg::MAX_PAGES_C)) begin
						fc_q <= fc_q + bcpa_pkg::CNT_W'(1);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the first-fit contiguous page allocator.
`timescale 1ns / 100ps

module testbench;

	// Undefined operation code, rejected by the block
	localparam logic [1:0] FUNC_UNDEF = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	bcpa_pkg::req_t             in_data;
	logic                       out_valid;
	logic                       out_ready;
	bcpa_pkg::resp_t            out_data;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [bcpa_pkg::CNT_W-1:0] cfg_data;

	// Shadow allocator state
	bit [bcpa_pkg::MAX_PAGES-1:0] pages_used;
	int unsigned                  free_tally;
	logic [bcpa_pkg::CNT_W-1:0]   total_reg;

	bcpa_pkg::resp_t due_replies[$];
	bcpa_pkg::resp_t head_reply;
	int unsigned     fault_count;

	// Receiver stall control
	int          hold_cycles;
	bit          rx_throttle;
	bit [15:0]   rx_pattern;
	int unsigned rx_phase;

	bitmap_contiguous_page_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// End a hung run
	initial begin
		#(30_000_000);
		$display("bitmap_contiguous_page_allocator: mismatch");
		$finish;
	end

	function automatic int unsigned pool_span();
		return (total_reg > bcpa_pkg::MAX_PAGES) ? bcpa_pkg::MAX_PAGES : int'(total_reg);
	endfunction

	// Apply one operation to the shadow state and return the reply it yields
	function automatic bcpa_pkg::resp_t apply_op(bcpa_pkg::req_t r);
		bcpa_pkg::resp_t res;
		int unsigned     span;
		int unsigned     want;
		int unsigned     run;
		int unsigned     base;
		bit              found;
		span           = pool_span();
		want           = r.page_count;
		run            = 0;
		base           = 0;
		found          = 1'b0;
		res            = '0;
		res.status     = bcpa_pkg::STAT_OK;
		case (r.func)
			bcpa_pkg::FUNC_ALLOC: begin
				if (free_tally == 0) begin
					res.status = bcpa_pkg::STAT_NO_FREE;
				end else if (want == 0) begin
					res.status = bcpa_pkg::STAT_BAD;
				end else begin
					// Scan upward for the lowest run of free pages
					for (int i = 0; i < span && !found; i++) begin
						run = pages_used[i] ? 0 : run + 1;
						if (run == want) begin
							base  = i + 1 - want;
							found = 1'b1;
						end
					end
					if (!found) begin
						res.status = bcpa_pkg::STAT_NO_FIT;
					end else begin
						for (int i = base; i < base + want; i++)
							pages_used[i] = 1'b1;
						free_tally     = (free_tally > want) ? free_tally - want : 0;
						res.start_page = bcpa_pkg::PAGE_W'(base);
					end
				end
			end
			bcpa_pkg::FUNC_FREE_ONE: begin
				if (r.page_number >= span) begin
					res.status = bcpa_pkg::STAT_BAD;
				end else if (pages_used[r.page_number]) begin
					pages_used[r.page_number] = 1'b0;
					if (free_tally < bcpa_pkg::MAX_PAGES)
						free_tally++;
				end
			end
			bcpa_pkg::FUNC_FREE_ALL: begin
				pages_used = '0;
				free_tally = span;
			end
			default: begin
				res.status = bcpa_pkg::STAT_BAD;
			end
		endcase
		res.free_pages = bcpa_pkg::CNT_W'(free_tally);
		return res;
	endfunction

	function automatic bcpa_pkg::req_t mk_req(logic [1:0] f, int unsigned cnt,
			int unsigned pg);
		bcpa_pkg::req_t r;
		r.func        = f;
		r.page_count  = bcpa_pkg::CNT_W'(cnt);
		r.page_number = bcpa_pkg::PAGE_W'(pg);
		return r;
	endfunction

	// Draw a request: mostly allocates and frees of used pages, some noise
	function automatic bcpa_pkg::req_t pick_req();
		bcpa_pkg::req_t r;
		int unsigned    span;
		int unsigned    pick;
		int unsigned    shape;
		int unsigned    pg;
		int unsigned    k;
		span          = pool_span();
		r.func        = bcpa_pkg::FUNC_ALLOC;
		r.page_count  = bcpa_pkg::CNT_W'($urandom_range(0, 1024));
		r.page_number = bcpa_pkg::PAGE_W'($urandom_range(0, 1023));
		pick          = $urandom_range(0, 99);
		shape         = $urandom_range(0, 99);
		if (pick < 50) begin
			if (shape < 60)
				r.page_count = bcpa_pkg::CNT_W'($urandom_range(1, 8));
			else if (shape < 85)
				r.page_count = bcpa_pkg::CNT_W'($urandom_range(1, 64));
			else if (shape < 97)
				r.page_count = bcpa_pkg::CNT_W'($urandom_range(1, (span == 0) ? 1 : span));
			else if ($urandom_range(0, 1))
				r.page_count = bcpa_pkg::CNT_W'(1024);
			else
				r.page_count = bcpa_pkg::CNT_W'((span >= 1024) ? 1024 : span + 1);
		end else if (pick < 90) begin
			r.func = bcpa_pkg::FUNC_FREE_ONE;
			if (span > 0 && shape < 90) begin
				// Walk forward to a page in use, if any
				pg = $urandom_range(0, span - 1);
				for (k = 0; k < span && !pages_used[pg]; k++)
					pg = (pg + 1 == span) ? 0 : pg + 1;
				r.page_number = bcpa_pkg::PAGE_W'(pg);
			end
		end else if (pick < 93) begin
			r.func = bcpa_pkg::FUNC_FREE_ALL;
		end else if (shape < 50) begin
			r.func = FUNC_UNDEF;
		end else begin
			r.page_count = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		fault_count++;
		$display("ERROR %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	// Offer one request and predict its reply once the transfer happens
	task automatic send_req(input bcpa_pkg::req_t r);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= r;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		due_replies.push_back(apply_op(r));
	endtask

	task automatic hold_in(input int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every reply has come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_total(input int unsigned v);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= bcpa_pkg::CNT_W'(v);
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		total_reg = bcpa_pkg::CNT_W'(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Check each reply against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_replies.size() == 0) begin
				report_mismatch("unexpected reply", 32'(out_data), 0);
			end else begin
				head_reply = due_replies.pop_front();
				if (out_data.status !== head_reply.status)
					report_mismatch("status", out_data.status, head_reply.status);
				if (out_data.start_page !== head_reply.start_page)
					report_mismatch("start_page", out_data.start_page,
						head_reply.start_page);
				if (out_data.free_pages !== head_reply.free_pages)
					report_mismatch("free_pages", out_data.free_pages,
						head_reply.free_pages);
			end
		end
	end

	// Drive out_ready: long hold, random pattern or always ready
	initial begin
		out_ready  = 1'b0;
		rx_pattern = 16'hFFFF;
		rx_phase   = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (!rx_throttle) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= rx_pattern[rx_phase];
				rx_phase = (rx_phase + 1) % 16;
				if (rx_phase == 0)
					rx_pattern = $urandom;
			end
		end
	end

	// Allocate at the field extremes, empty pool, zero length and bad opcode
	task automatic test_alloc_edges();
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 0, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1024, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1023, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 0, 1023));
		send_req(mk_req(FUNC_UNDEF, 2047, 1023));
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ALL, 0, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1024, 0));
	endtask

	// Release pages, including one already free, then fit around the holes
	task automatic test_free_one();
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ONE, 0, 1023));
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ONE, 0, 1023));
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ONE, 0, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 2, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1, 0));
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ALL, 0, 0));
	endtask

	// Small, empty and oversized pools; stale count after a resize
	task automatic test_pool_size();
		write_total(8);
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ALL, 0, 0));
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ONE, 0, 8));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 9, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 8, 0));
		write_total(0);
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ALL, 0, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1, 0));
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ONE, 0, 0));
		write_total(2047);
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ALL, 0, 0));
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1024, 0));
		// Free-all must clear pages beyond the pool too
		write_total(8);
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ALL, 0, 0));
		write_total(1024);
		send_req(mk_req(bcpa_pkg::FUNC_ALLOC, 1000, 0));
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ALL, 0, 0));
	endtask

	// Hold off the receiver while requests keep coming, so the input stalls
	task automatic test_backpressure();
		wait_idle();
		@(posedge clk);
		hold_cycles = 300;
		for (int i = 0; i < 10; i++)
			send_req((i % 2) ? mk_req(bcpa_pkg::FUNC_FREE_ONE, 0, i)
				: mk_req(bcpa_pkg::FUNC_ALLOC, i + 1, 0));
	endtask

	// Random traffic over one pool size, with sender bursts and receiver stalls
	task automatic test_random_phase(input int unsigned pool, input int unsigned items);
		int unsigned burst;
		burst = 0;
		write_total(pool);
		send_req(mk_req(bcpa_pkg::FUNC_FREE_ALL, 0, 0));
		for (int n = 0; n < items; n++) begin
			if (burst == 0) begin
				burst       = $urandom_range(1, 24);
				rx_throttle = ($urandom_range(0, 3) != 0);
				hold_in(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
			end
			send_req(pick_req());
			burst--;
		end
		rx_throttle = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		hold_cycles = 0;
		rx_throttle = 1'b0;
		fault_count = 0;
		pages_used  = '0;
		free_tally  = bcpa_pkg::MAX_PAGES;
		total_reg   = bcpa_pkg::TOTAL_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_alloc_edges();
		test_free_one();
		test_pool_size();
		test_backpressure();
		test_random_phase(1024, 400);
		test_random_phase(37, 150);
		test_random_phase(2047, 200);
		test_random_phase(256, 250);
		test_random_phase(1, 50);
		test_random_phase(1024, 250);

		wait_idle();
		repeat (50) @(posedge clk);
		if (fault_count == 0)
			$display("bitmap_contiguous_page_allocator: match");
		else
			$display("bitmap_contiguous_page_allocator: mismatch");
		$finish;
	end

endmodule
